// ===== src/prpe_pkg.sv =====
package prpe_pkg;

    // Request codes
    localparam logic [1:0] REQ_SPAWN = 2'd0;
    localparam logic [1:0] REQ_TICK  = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_FRICTION = 2'd0;
    localparam logic [1:0] CFG_BOUNCE   = 2'd1;
    localparam logic [1:0] CFG_GRAVITY  = 2'd2;
    localparam logic [1:0] CFG_LIFE     = 2'd3;

    // Configuration reset values
    localparam logic [15:0] FRICTION_RST = 16'd64225;
    localparam logic [15:0] BOUNCE_RST   = 16'd45875;
    localparam logic [15:0] GRAVITY_RST  = 16'd5243;
    localparam logic [7:0]  LIFE_RST     = 8'd80;

    // Extra trail damping 0.97 in Q0.16, and jitter LFSR feedback
    localparam logic [15:0] DAMP_Q16  = 16'd63570;
    localparam logic [31:0] LFSR_MASK = 32'hA300_0000;
    localparam logic [31:0] LFSR_SEED = 32'd1;
    localparam logic [15:0] JIT_MID   = 16'd16384;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_SP_MUL,
        ST_SP_ADD,
        ST_SP_PART,
        ST_SP_TRAIL,
        ST_TK_RD,
        ST_TK_LD,
        ST_TK_MX,
        ST_TK_MY,
        ST_TK_MY2,
        ST_TK_MZ,
        ST_TK_ADD,
        ST_TK_BNC,
        ST_TK_BW,
        ST_TK_WR,
        ST_TK_END,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_DONE
    } state_t;

    // One trail point
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } point_t;

    // Per-particle record
    typedef struct packed {
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] gnd;
        logic [7:0]         timer;
    } part_t;

    // Saturating Q16.16 add
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sat_add = s[31:0];
    endfunction

    // Magnitude, most negative value clamps to most positive
    function automatic logic signed [31:0] abs_sat(input logic signed [31:0] a);
        if (a == 32'sh8000_0000)
            abs_sat = 32'sh7FFF_FFFF;
        else if (a < 0)
            abs_sat = -a;
        else
            abs_sat = a;
    endfunction

endpackage

// ===== src/particle_ring_physics_engine.sv =====
// Tick walks the live particles and their trail points one at a time through the single shared
// gain multiplier, with registered reads of the particle and trail memories.
// One request at a time; a result is shown for one cycle on done and cannot be stalled.
// Reset clears ring head, count, LFSR (seed 1) and gains to defaults; memories are
// not cleared and need no clearing pass.
module particle_ring_physics_engine #(
    parameter int CAPACITY     = 255,
    parameter int TRAIL_POINTS = 6
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_wdata,
    input  logic [1:0]         req_type,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic [30:0]        spread,
    input  logic signed [31:0] floor_height,
    input  logic [7:0]         read_index,
    input  logic [2:0]         read_point,
    output logic               done,
    output logic signed [31:0] point_x,
    output logic signed [31:0] point_y,
    output logic signed [31:0] point_z,
    output logic [7:0]         live_count,
    output logic               valid_res
);

    localparam int SLOT_W  = $clog2(CAPACITY);
    localparam int PT_W    = $clog2(TRAIL_POINTS + 1);
    localparam int TDEPTH  = CAPACITY * TRAIL_POINTS;
    localparam int TADDR_W = $clog2(TDEPTH);
    localparam int CMP_W   = ((SLOT_W > 8) ? SLOT_W : 8) + 1;

    // Control registers
    prpe_pkg::state_t   state_reg, state_next;
    logic [SLOT_W-1:0]  head_reg, count_reg, slot_reg, n_reg, last_dead_reg;
    logic               dead_any_reg;
    logic [PT_W-1:0]    p_reg;
    logic [1:0]         a_reg;
    logic [31:0]        lfsr_reg;
    logic [15:0]        friction_reg, bounce_reg, gravity_reg;
    logic [7:0]         life_reg;

    // Payload registers
    logic [TADDR_W-1:0] base_reg;
    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic signed [31:0] gnd_reg;
    logic [7:0]         timer_reg;
    logic [30:0]        spread_reg;
    logic signed [47:0] jprod_reg;
    logic [15:0]        tg_reg;
    logic signed [31:0] out_x_reg, out_y_reg, out_z_reg;
    logic               valid_reg;
    logic [1:0]         req_reg;

    // Memories
    prpe_pkg::part_t    part_mem [CAPACITY];
    prpe_pkg::point_t   trail_mem [TDEPTH];
    prpe_pkg::part_t    part_rdata_reg;
    prpe_pkg::point_t   trail_rdata_reg;

    logic               part_we, trail_we;
    prpe_pkg::part_t    part_wdata;
    prpe_pkg::point_t   trail_wdata;
    logic [TADDR_W-1:0] trail_waddr;

    // Multiplier
    logic signed [31:0] mul_a, mul_res;
    logic [15:0]        mul_g;

    logic               accept;
    logic [31:0]        lfsr_step;
    logic signed [15:0] r_off;
    logic [7:0]         timer_dec;
    logic signed [31:0] neg_grav;
    logic [31:0]        tg_prod;
    logic               last_point, last_part;

    // Spawn ring update
    logic [SLOT_W-1:0]  sp_head, sp_count, sp_slot;
    logic [SLOT_W:0]    sp_sum;

    // Read address
    logic [CMP_W-1:0]   rd_sum;
    logic [SLOT_W-1:0]  rd_slot;
    logic               rd_ok;

    // Tick retire
    logic [SLOT_W:0]    gone, ret_sum;
    logic [SLOT_W-1:0]  ret_count;

    prpe_gmul u_gmul (
        .clk (clk),
        .a   (mul_a),
        .g   (mul_g),
        .res (mul_res)
    );

    assign accept     = start && (state_reg == prpe_pkg::ST_IDLE);
    assign busy       = (state_reg != prpe_pkg::ST_IDLE);
    assign done       = (state_reg == prpe_pkg::ST_DONE);
    assign point_x    = out_x_reg;
    assign point_y    = out_y_reg;
    assign point_z    = out_z_reg;
    assign valid_res  = valid_reg;
    assign live_count = (CMP_W'(count_reg) > CMP_W'(255)) ? 8'd255 : 8'(count_reg);

    assign lfsr_step = {1'b0, lfsr_reg[31:1]} ^ (lfsr_reg[0] ? prpe_pkg::LFSR_MASK : 32'd0);
    assign r_off     = $signed({1'b0, lfsr_step[14:0]}) - $signed(prpe_pkg::JIT_MID);
    assign timer_dec = (timer_reg <= 8'd1) ? 8'd0 : timer_reg - 8'd1;
    assign neg_grav  = $signed(32'd0) - $signed({16'd0, gravity_reg});
    assign tg_prod   = prpe_pkg::DAMP_Q16 * friction_reg;
    assign last_point = (p_reg == PT_W'(TRAIL_POINTS - 1));
    assign last_part  = ((SLOT_W + 1)'(n_reg) + 1'b1 == (SLOT_W + 1)'(count_reg));

    // Spawn: advance head when full, place new particle at tail
    always_comb
    begin
        if (count_reg >= SLOT_W'(CAPACITY - 1))
        begin
            sp_head  = (head_reg == SLOT_W'(CAPACITY - 1)) ? '0 : head_reg + 1'b1;
            sp_count = SLOT_W'(CAPACITY - 1);
        end
        else
        begin
            sp_head  = head_reg;
            sp_count = count_reg + 1'b1;
        end
        sp_sum  = (SLOT_W + 1)'(sp_head) + (SLOT_W + 1)'(sp_count) - 1'b1;
        sp_slot = (sp_sum >= (SLOT_W + 1)'(CAPACITY)) ?
                  SLOT_W'(sp_sum - (SLOT_W + 1)'(CAPACITY)) : SLOT_W'(sp_sum);
    end

    // Read: age order to slot
    always_comb
    begin
        rd_ok   = (CMP_W'(read_index) < CMP_W'(count_reg)) &&
                  (int'(read_point) < TRAIL_POINTS);
        rd_sum  = CMP_W'(head_reg) + CMP_W'(read_index);
        rd_slot = (rd_sum >= CMP_W'(CAPACITY)) ?
                  SLOT_W'(rd_sum - CMP_W'(CAPACITY)) : SLOT_W'(rd_sum);
    end

    // Retire up to the last expired particle
    always_comb
    begin
        gone      = (SLOT_W + 1)'(last_dead_reg) + 1'b1;
        ret_count = dead_any_reg ? SLOT_W'((SLOT_W + 1)'(count_reg) - gone) : count_reg;
        ret_sum   = (SLOT_W + 1)'(head_reg) + (dead_any_reg ? gone : '0);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prpe_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req_type)
                        prpe_pkg::REQ_SPAWN: state_next = prpe_pkg::ST_SP_MUL;
                        prpe_pkg::REQ_TICK:  state_next = (count_reg == '0) ?
                                                 prpe_pkg::ST_DONE : prpe_pkg::ST_TK_RD;
                        prpe_pkg::REQ_READ:  state_next = prpe_pkg::ST_RD_ADDR;
                        default:             state_next = prpe_pkg::ST_DONE;
                    endcase
                end
            end
            prpe_pkg::ST_SP_MUL:   state_next = prpe_pkg::ST_SP_ADD;
            prpe_pkg::ST_SP_ADD:   state_next = (a_reg == 2'd2) ?
                                       prpe_pkg::ST_SP_PART : prpe_pkg::ST_SP_MUL;
            prpe_pkg::ST_SP_PART:  state_next = prpe_pkg::ST_SP_TRAIL;
            prpe_pkg::ST_SP_TRAIL: state_next = last_point ?
                                       prpe_pkg::ST_DONE : prpe_pkg::ST_SP_TRAIL;
            prpe_pkg::ST_TK_RD:    state_next = prpe_pkg::ST_TK_LD;
            prpe_pkg::ST_TK_LD:    state_next = prpe_pkg::ST_TK_MX;
            prpe_pkg::ST_TK_MX:    state_next = prpe_pkg::ST_TK_MY;
            prpe_pkg::ST_TK_MY:    state_next = (p_reg == '0) ?
                                       prpe_pkg::ST_TK_MZ : prpe_pkg::ST_TK_MY2;
            prpe_pkg::ST_TK_MY2:   state_next = prpe_pkg::ST_TK_MZ;
            prpe_pkg::ST_TK_MZ:    state_next = prpe_pkg::ST_TK_ADD;
            prpe_pkg::ST_TK_ADD:   state_next = prpe_pkg::ST_TK_BNC;
            prpe_pkg::ST_TK_BNC:   state_next = (pos_reg[1] < gnd_reg) ?
                                       prpe_pkg::ST_TK_BW : prpe_pkg::ST_TK_WR;
            prpe_pkg::ST_TK_BW:    state_next = prpe_pkg::ST_TK_WR;
            prpe_pkg::ST_TK_WR:
            begin
                if (!last_point)
                    state_next = prpe_pkg::ST_TK_MX;
                else
                    state_next = last_part ? prpe_pkg::ST_TK_END : prpe_pkg::ST_TK_RD;
            end
            prpe_pkg::ST_TK_END:   state_next = prpe_pkg::ST_DONE;
            prpe_pkg::ST_RD_ADDR:  state_next = prpe_pkg::ST_RD_DATA;
            prpe_pkg::ST_RD_DATA:  state_next = prpe_pkg::ST_DONE;
            prpe_pkg::ST_DONE:     state_next = prpe_pkg::ST_IDLE;
            default:               state_next = prpe_pkg::ST_IDLE;
        endcase
    end

    // Memory writes and multiplier operands
    always_comb
    begin
        part_we     = 1'b0;
        trail_we    = 1'b0;
        trail_waddr = base_reg + TADDR_W'(p_reg);
        trail_wdata = '{x: pos_reg[0], y: pos_reg[1], z: pos_reg[2]};
        part_wdata  = '{vx: vel_reg[0], vy: vel_reg[1], vz: vel_reg[2],
                        gnd: gnd_reg, timer: timer_reg};
        mul_a       = vel_reg[0];
        mul_g       = friction_reg;
        unique case (state_reg)
            prpe_pkg::ST_SP_PART:  part_we = 1'b1;
            prpe_pkg::ST_SP_TRAIL: trail_we = 1'b1;
            prpe_pkg::ST_TK_MX:
            begin
                mul_a = vel_reg[0];
                mul_g = (p_reg == '0) ? friction_reg : tg_reg;
            end
            prpe_pkg::ST_TK_MY:
            begin
                mul_a = vel_reg[1];
                mul_g = friction_reg;
            end
            prpe_pkg::ST_TK_MY2:
            begin
                mul_a = mul_res;
                mul_g = prpe_pkg::DAMP_Q16;
            end
            prpe_pkg::ST_TK_MZ:
            begin
                mul_a = vel_reg[2];
                mul_g = (p_reg == '0) ? friction_reg : tg_reg;
            end
            prpe_pkg::ST_TK_BNC:
            begin
                mul_a = prpe_pkg::abs_sat(vel_reg[1]);
                mul_g = bounce_reg;
            end
            prpe_pkg::ST_TK_WR:
            begin
                trail_we = 1'b1;
                part_we  = (p_reg == '0);
                part_wdata.timer = timer_dec;
            end
            default: ;
        endcase
    end

    // Memories, one write and one registered read each
    always_ff @(posedge clk)
    begin
        if (part_we)
            part_mem[slot_reg] <= part_wdata;
        part_rdata_reg <= part_mem[slot_reg];
    end

    always_ff @(posedge clk)
    begin
        if (trail_we)
            trail_mem[trail_waddr] <= trail_wdata;
        trail_rdata_reg <= trail_mem[base_reg];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prpe_pkg::ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            slot_reg      <= '0;
            n_reg         <= '0;
            last_dead_reg <= '0;
            dead_any_reg  <= 1'b0;
            p_reg         <= '0;
            a_reg         <= '0;
            lfsr_reg      <= prpe_pkg::LFSR_SEED;
            friction_reg  <= prpe_pkg::FRICTION_RST;
            bounce_reg    <= prpe_pkg::BOUNCE_RST;
            gravity_reg   <= prpe_pkg::GRAVITY_RST;
            life_reg      <= prpe_pkg::LIFE_RST;
        end
        else
        begin
            state_reg <= state_next;

            // Configuration writes
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    prpe_pkg::CFG_FRICTION: friction_reg <= cfg_wdata;
                    prpe_pkg::CFG_BOUNCE:   bounce_reg   <= cfg_wdata;
                    prpe_pkg::CFG_GRAVITY:  gravity_reg  <= cfg_wdata;
                    prpe_pkg::CFG_LIFE:     life_reg     <= cfg_wdata[7:0];
                    default: ;
                endcase
            end

            if (accept)
            begin
                p_reg <= '0;
                a_reg <= '0;
                if (req_type == prpe_pkg::REQ_SPAWN)
                begin
                    head_reg  <= sp_head;
                    count_reg <= sp_count;
                    slot_reg  <= sp_slot;
                end
                else if (req_type == prpe_pkg::REQ_TICK)
                begin
                    slot_reg     <= head_reg;
                    n_reg        <= '0;
                    dead_any_reg <= 1'b0;
                end
            end

            case (state_reg)
                prpe_pkg::ST_SP_MUL: lfsr_reg <= lfsr_step;
                prpe_pkg::ST_SP_ADD: a_reg <= a_reg + 1'b1;
                prpe_pkg::ST_SP_TRAIL: p_reg <= p_reg + 1'b1;
                prpe_pkg::ST_TK_WR:
                begin
                    if (p_reg == '0 && timer_reg <= 8'd1)
                    begin
                        dead_any_reg  <= 1'b1;
                        last_dead_reg <= n_reg;
                    end
                    if (last_point)
                    begin
                        p_reg    <= '0;
                        n_reg    <= n_reg + 1'b1;
                        slot_reg <= (slot_reg == SLOT_W'(CAPACITY - 1)) ? '0 : slot_reg + 1'b1;
                    end
                    else
                        p_reg <= p_reg + 1'b1;
                end
                prpe_pkg::ST_TK_END:
                begin
                    count_reg <= ret_count;
                    if (ret_count == '0)
                        head_reg <= '0;
                    else
                        head_reg <= (ret_sum >= (SLOT_W + 1)'(CAPACITY)) ?
                                    SLOT_W'(ret_sum - (SLOT_W + 1)'(CAPACITY)) :
                                    SLOT_W'(ret_sum);
                end
                default: ;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg   <= req_type;
            out_x_reg <= '0;
            out_y_reg <= '0;
            out_z_reg <= '0;
            valid_reg <= 1'b1;
            tg_reg    <= tg_prod[31:16];
            if (req_type == prpe_pkg::REQ_SPAWN)
            begin
                pos_reg[0] <= pos_x;
                pos_reg[1] <= pos_y;
                pos_reg[2] <= pos_z;
                vel_reg[0] <= vel_x;
                vel_reg[1] <= vel_y;
                vel_reg[2] <= vel_z;
                spread_reg <= spread;
                gnd_reg    <= floor_height;
                timer_reg  <= life_reg;
            end
            else if (req_type == prpe_pkg::REQ_TICK)
                base_reg <= TADDR_W'(int'(head_reg) * TRAIL_POINTS);
            else if (req_type == prpe_pkg::REQ_READ)
            begin
                valid_reg <= rd_ok;
                base_reg  <= TADDR_W'(int'(rd_slot) * TRAIL_POINTS + int'(read_point));
            end
        end

        case (state_reg)
            // Spawn jitter: SP_MUL forms the product, SP_ADD adds it to one axis
            prpe_pkg::ST_SP_MUL:
                jprod_reg <= $signed({1'b0, spread_reg}) * r_off;
            prpe_pkg::ST_SP_ADD:
            begin
                if (a_reg <= 2'd2)
                    vel_reg[a_reg] <= prpe_pkg::sat_add(vel_reg[a_reg], jprod_reg[45:14]);
                base_reg <= TADDR_W'(int'(slot_reg) * TRAIL_POINTS);
            end
            // Tick, one particle after another
            prpe_pkg::ST_TK_LD:
            begin
                vel_reg[0] <= part_rdata_reg.vx;
                vel_reg[1] <= part_rdata_reg.vy;
                vel_reg[2] <= part_rdata_reg.vz;
                gnd_reg    <= part_rdata_reg.gnd;
                timer_reg  <= part_rdata_reg.timer;
                pos_reg[0] <= trail_rdata_reg.x;
                pos_reg[1] <= trail_rdata_reg.y;
                pos_reg[2] <= trail_rdata_reg.z;
            end
            prpe_pkg::ST_TK_MY: vel_reg[0] <= mul_res;
            prpe_pkg::ST_TK_MZ: vel_reg[1] <= prpe_pkg::sat_add(mul_res, neg_grav);
            prpe_pkg::ST_TK_ADD:
            begin
                vel_reg[2] <= mul_res;
                pos_reg[0] <= prpe_pkg::sat_add(pos_reg[0], vel_reg[0]);
                pos_reg[1] <= prpe_pkg::sat_add(pos_reg[1], vel_reg[1]);
                pos_reg[2] <= prpe_pkg::sat_add(pos_reg[2], mul_res);
            end
            prpe_pkg::ST_TK_BNC:
                if (pos_reg[1] < gnd_reg)
                    pos_reg[1] <= gnd_reg;
            prpe_pkg::ST_TK_BW: vel_reg[1] <= mul_res;
            prpe_pkg::ST_TK_WR:
                if (last_point)
                    base_reg <= (slot_reg == SLOT_W'(CAPACITY - 1)) ? '0 :
                                base_reg + TADDR_W'(TRAIL_POINTS);
            // Read result
            prpe_pkg::ST_RD_DATA:
                if (valid_reg && req_reg == prpe_pkg::REQ_READ)
                begin
                    out_x_reg <= trail_rdata_reg.x;
                    out_y_reg <= trail_rdata_reg.y;
                    out_z_reg <= trail_rdata_reg.z;
                end
            default: ;
        endcase
    end

endmodule

// ===== src/prpe_gmul.sv =====
// Gain multiply: signed Q16.16 times unsigned Q0.16, floor rounding,
// registered result in the cycle after the operands.
module prpe_gmul (
    input  logic               clk,
    input  logic signed [31:0] a,
    input  logic        [15:0] g,
    output logic signed [31:0] res
);

    logic signed [48:0] prod;
    logic signed [31:0] res_reg;

    // |a*g| < 2^47, so the shifted product always fits 32 bits
    assign prod = a * $signed({1'b0, g});

    always_ff @(posedge clk)
    begin
        res_reg <= prod[47:16];
    end

    assign res = res_reg;

endmodule

// ===== test/particle_ring_physics_engine_test.sv =====
module particle_ring_physics_engine_test;

    localparam int RING_SLOTS = 255;
    localparam int TRAIL_LEN  = 6;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct {
        logic [1:0]         kind;
        logic signed [31:0] px, py, pz;
        logic signed [31:0] vx, vy, vz;
        logic [30:0]        spread;
        logic signed [31:0] ground;
        logic [7:0]         index;
        logic [2:0]         point;
    } request_t;

    typedef struct {
        logic signed [31:0] x, y, z;
        logic [7:0]         live;
        logic               valid;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    logic cfg_wr_en = 1'b0;
    logic [1:0] cfg_index = prpe_pkg::CFG_FRICTION;
    logic [15:0] cfg_wdata = '0;
    logic done;
    logic signed [31:0] point_x, point_y, point_z;
    logic [7:0] live_count;
    logic valid_res;

    request_t cur = '{prpe_pkg::REQ_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    request_t pending_q[$];
    answer_t  answer_q[$];

    particle_ring_physics_engine uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .req_type(cur.kind), .pos_x(cur.px), .pos_y(cur.py), .pos_z(cur.pz),
        .vel_x(cur.vx), .vel_y(cur.vy), .vel_z(cur.vz), .spread(cur.spread),
        .floor_height(cur.ground), .read_index(cur.index), .read_point(cur.point),
        .done(done), .point_x(point_x), .point_y(point_y), .point_z(point_z),
        .live_count(live_count), .valid_res(valid_res)
    );

    // Shadow state of the particle ring
    int          trail_x[RING_SLOTS][TRAIL_LEN];
    int          trail_y[RING_SLOTS][TRAIL_LEN];
    int          trail_z[RING_SLOTS][TRAIL_LEN];
    int          speed_x[RING_SLOTS], speed_y[RING_SLOTS], speed_z[RING_SLOTS];
    int          ground_h[RING_SLOTS];
    int unsigned life_left[RING_SLOTS];
    int unsigned head, live;
    logic [31:0] jitter;
    int unsigned friction, bounce, gravity, life_init;

    int errors, n_spawn, n_tick, n_read, n_bad_read, n_overwrite, n_retired, n_checked;

    function automatic int sat32(longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return int'(v);
    endfunction

    // Q16.16 times unsigned Q0.16, floor rounding
    function automatic int scale(int v, int unsigned g);
        longint p;
        p = longint'(v) * longint'(g);
        return sat32(p >>> 16);
    endfunction

    function automatic int magnitude(int v);
        if (v == 32'sh8000_0000) return 32'sh7FFF_FFFF;
        return v < 0 ? -v : v;
    endfunction

    function automatic int jitter_draw(logic [30:0] amp);
        logic out;
        longint r;
        out = jitter[0];
        jitter = jitter >> 1;
        if (out) jitter = jitter ^ prpe_pkg::LFSR_MASK;
        r = longint'(jitter[14:0]) - 16384;
        return sat32((longint'(amp) * r) >>> 14);
    endfunction

    // Apply one transaction to the shadow ring and queue the answer
    function automatic void predict_answer(request_t rq);
        answer_t a;
        int unsigned slot, idx, tg;
        int vx, vy, vz, px, py, pz, g;
        int dead;
        a = '{0, 0, 0, 0, 1'b1};
        case (rq.kind)
            prpe_pkg::REQ_SPAWN: begin
                n_spawn++;
                if (live >= RING_SLOTS - 1) begin
                    head = (head + 1) % RING_SLOTS;
                    n_overwrite++;
                end
                else
                    live++;
                slot = (head + live - 1) % RING_SLOTS;
                speed_x[slot] = sat32(longint'(rq.vx) + jitter_draw(rq.spread));
                speed_y[slot] = sat32(longint'(rq.vy) + jitter_draw(rq.spread));
                speed_z[slot] = sat32(longint'(rq.vz) + jitter_draw(rq.spread));
                for (int p = 0; p < TRAIL_LEN; p++)
                begin
                    trail_x[slot][p] = rq.px;
                    trail_y[slot][p] = rq.py;
                    trail_z[slot][p] = rq.pz;
                end
                ground_h[slot] = rq.ground;
                life_left[slot] = life_init;
            end
            prpe_pkg::REQ_TICK: begin
                n_tick++;
                tg = (prpe_pkg::DAMP_Q16 * friction) >> 16;
                dead = -1;
                idx = head;
                for (int n = 0; n < live; n++)
                begin
                    g = ground_h[idx];
                    px = trail_x[idx][0];
                    py = trail_y[idx][0];
                    pz = trail_z[idx][0];
                    vx = scale(speed_x[idx], friction);
                    vy = sat32(longint'(scale(speed_y[idx], friction)) - gravity);
                    vz = scale(speed_z[idx], friction);
                    for (int p = 0; p < TRAIL_LEN; p++)
                    begin
                        if (p > 0) begin
                            vx = scale(vx, tg);
                            vy = sat32(longint'(scale(scale(vy, friction), prpe_pkg::DAMP_Q16))
                                       - gravity);
                            vz = scale(vz, tg);
                        end
                        px = sat32(longint'(px) + vx);
                        py = sat32(longint'(py) + vy);
                        pz = sat32(longint'(pz) + vz);
                        if (py < g) begin
                            py = g;
                            vy = scale(magnitude(vy), bounce);
                        end
                        if (p == 0) begin
                            speed_x[idx] = vx;
                            speed_y[idx] = vy;
                            speed_z[idx] = vz;
                        end
                        trail_x[idx][p] = px;
                        trail_y[idx][p] = py;
                        trail_z[idx][p] = pz;
                    end
                    if (life_left[idx] <= 1) begin
                        life_left[idx] = 0;
                        dead = n;
                    end
                    else
                        life_left[idx]--;
                    idx = (idx + 1) % RING_SLOTS;
                end
                if (dead >= 0) begin
                    live -= dead + 1;
                    head = (head + dead + 1) % RING_SLOTS;
                    n_retired += dead + 1;
                end
                if (live == 0) head = 0;
            end
            prpe_pkg::REQ_READ: begin
                n_read++;
                if (rq.index < live && rq.point < TRAIL_LEN) begin
                    slot = (head + rq.index) % RING_SLOTS;
                    a.x = trail_x[slot][rq.point];
                    a.y = trail_y[slot][rq.point];
                    a.z = trail_z[slot][rq.point];
                end
                else begin
                    a.valid = 1'b0;
                    n_bad_read++;
                end
            end
            default: ;
        endcase
        a.live = live > 255 ? 8'd255 : live[7:0];
        answer_q.push_back(a);
    endfunction

    task automatic report(string what, longint got, longint want);
        errors++;
        $display("mismatch %s: got %0h expected %0h (answer %0d)", what, got, want, n_checked);
    endtask

    // Clock and reset
    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Driver: bursts of transactions with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(posedge clk)
    begin
        logic taken;
        if (rst_n) begin
            taken = start && !busy;
            if (taken) begin
                predict_answer(cur);
                burst_left--;
            end
            if (!start || taken) begin
                if (burst_left <= 0) begin
                    burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 40 : 8);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end
                else if (pending_q.size() > 0) begin
                    cur <= pending_q.pop_front();
                    start <= 1'b1;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // Monitor: compare each answer with the oldest prediction
    always @(posedge clk)
    begin
        answer_t w;
        if (rst_n && done) begin
            if (answer_q.size() == 0)
                report("unexpected answer, live_count", live_count, 0);
            else begin
                w = answer_q.pop_front();
                if (point_x !== w.x) report("point_x", point_x, w.x);
                if (point_y !== w.y) report("point_y", point_y, w.y);
                if (point_z !== w.z) report("point_z", point_z, w.z);
                if (live_count !== w.live) report("live_count", live_count, w.live);
                if (valid_res !== w.valid) report("valid_res", valid_res, w.valid);
                n_checked++;
            end
        end
    end

    // Random Q16.16 value: mostly moderate, sometimes full range or extreme
    function automatic logic signed [31:0] any_q16();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return $signed($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
        endcase
    endfunction

    function automatic request_t make_request(logic [1:0] kind, int max_index);
        request_t r;
        r.kind = kind;
        r.px = any_q16();
        r.py = any_q16();
        r.pz = any_q16();
        r.vx = any_q16();
        r.vy = any_q16();
        r.vz = any_q16();
        r.spread = $urandom_range(0, 2) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 32'h4_0000));
        // Ground usually just under the spawn point so bounces happen
        r.ground = $urandom_range(0, 3) == 0 ? any_q16()
                                             : r.py - $signed($urandom_range(0, 32'h8_0000));
        r.index = $urandom_range(0, 9) == 0 ? 8'($urandom()) : 8'($urandom_range(0, max_index));
        r.point = $urandom_range(0, 7) == 0 ? 3'($urandom()) : 3'($urandom_range(0, 5));
        return r;
    endfunction

    // Random mix weighted by spawn, tick and read shares
    task automatic queue_mix(int count, int w_spawn, int w_tick, int max_index);
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick == 99)
                pending_q.push_back(make_request(REQ_NONE, max_index));
            else if (pick < w_spawn)
                pending_q.push_back(make_request(prpe_pkg::REQ_SPAWN, max_index));
            else if (pick < w_spawn + w_tick)
                pending_q.push_back(make_request(prpe_pkg::REQ_TICK, max_index));
            else
                pending_q.push_back(make_request(prpe_pkg::REQ_READ, max_index));
        end
    endtask

    task automatic wait_idle();
        while (pending_q.size() != 0 || start || busy || answer_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_gain(logic [1:0] index, logic [15:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        case (index)
            prpe_pkg::CFG_FRICTION: friction = value;
            prpe_pkg::CFG_BOUNCE:   bounce = value;
            prpe_pkg::CFG_GRAVITY:  gravity = value;
            default:                life_init = value[7:0];
        endcase
    endtask

    task automatic set_gains(logic [15:0] f, logic [15:0] b, logic [15:0] g, logic [7:0] l);
        wait_idle();
        write_gain(prpe_pkg::CFG_FRICTION, f);
        write_gain(prpe_pkg::CFG_BOUNCE, b);
        write_gain(prpe_pkg::CFG_GRAVITY, g);
        write_gain(prpe_pkg::CFG_LIFE, {8'd0, l});
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Stimulus phases
    initial
    begin
        request_t r;
        head = 0;
        live = 0;
        jitter = prpe_pkg::LFSR_SEED;
        friction = prpe_pkg::FRICTION_RST;
        bounce = prpe_pkg::BOUNCE_RST;
        gravity = prpe_pkg::GRAVITY_RST;
        life_init = prpe_pkg::LIFE_RST;
        @(posedge rst_n);

        // Directed: empty ring, unused code, extreme spawns, every trail point
        pending_q.push_back(make_request(prpe_pkg::REQ_TICK, 0));
        r = make_request(prpe_pkg::REQ_READ, 0);
        r.index = 0;
        r.point = 0;
        pending_q.push_back(r);
        pending_q.push_back(make_request(REQ_NONE, 0));
        r = make_request(prpe_pkg::REQ_SPAWN, 0);
        r.px = 32'sh7FFF_FFFF; r.py = 32'sh8000_0000; r.pz = 32'sh7FFF_FFFF;
        r.vx = 32'sh7FFF_FFFF; r.vy = 32'sh8000_0000; r.vz = 32'sh8000_0000;
        r.spread = 31'h7FFF_FFFF; r.ground = 32'sh7FFF_FFFF;
        pending_q.push_back(r);
        r = make_request(prpe_pkg::REQ_SPAWN, 0);
        r.px = 32'sh8000_0000; r.py = 32'sh7FFF_FFFF; r.pz = 0;
        r.vx = 32'sh8000_0000; r.vy = 32'sh7FFF_FFFF; r.vz = 0;
        r.spread = 0; r.ground = 32'sh8000_0000;
        pending_q.push_back(r);
        pending_q.push_back(make_request(prpe_pkg::REQ_SPAWN, 0));
        pending_q.push_back(make_request(prpe_pkg::REQ_TICK, 0));
        for (int p = 0; p < 8; p++)
        begin
            r = make_request(prpe_pkg::REQ_READ, 0);
            r.index = 8'(p % 3);
            r.point = 3'(p);
            pending_q.push_back(r);
        end
        r.index = 8'd255;
        r.point = 3'd0;
        pending_q.push_back(r);
        pending_q.push_back(make_request(prpe_pkg::REQ_TICK, 0));
        r.index = 8'd2;
        pending_q.push_back(r);

        // Extreme gains, one-tick lifetime: everything retires
        set_gains(16'hFFFF, 16'h0000, 16'hFFFF, 8'd1);
        queue_mix(20, 45, 25, 6);

        // Zero friction, full bounce, longest lifetime: fill the ring past capacity
        set_gains(16'h0000, 16'hFFFF, 16'h0000, 8'd255);
        queue_mix(275, 92, 2, 254);

        // Random gains with short lifetimes for mixed retirement
        set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()), 8'($urandom_range(1, 12)));
        queue_mix(40, 40, 20, 30);
        set_gains(prpe_pkg::FRICTION_RST, prpe_pkg::BOUNCE_RST, prpe_pkg::GRAVITY_RST,
                  prpe_pkg::LIFE_RST);
        queue_mix(20, 30, 20, 30);

        wait_idle();
        $display("covered %0d spawns (%0d overwrites), %0d ticks (%0d retired), %0d reads",
                 n_spawn, n_overwrite, n_tick, n_retired, n_read);
        $display("%0d reads out of range, %0d answers checked", n_bad_read, n_checked);
        if (errors == 0)
            $display("** particle_ring_physics_engine: PASSED **");
        else
            $display("** particle_ring_physics_engine: FAILED **");
        $finish;
    end

    // Watchdog
    initial
    begin
        #40000000;
        $display("** particle_ring_physics_engine: FAILED **");
        $finish;
    end

endmodule

// ===== particle_ring_physics_engine.f =====
src/prpe_pkg.sv
src/prpe_gmul.sv
src/particle_ring_physics_engine.sv
test/particle_ring_physics_engine_test.sv
